/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the complex matrix-vector block.
// Needs nothing else; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, ignored while reset is high.
`define CHECK_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define CHECK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/core/cmva_pkg.sv */
// Types, codes and helpers for the complex matrix-vector block.
// No dependencies; imported by every module of the block.
package cmva_pkg;

  // Function codes of an input beat
  localparam logic [1:0] FUNC_MAT    = 2'd0;
  localparam logic [1:0] FUNC_VEC    = 2'd1;
  localparam logic [1:0] FUNC_APPLY  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int ROUND_BIAS = 8192;
  localparam int FRAC_BITS  = 14;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
  } item_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [15:0] amp_re;
    logic signed [15:0] amp_im;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {OP_MAT, OP_VEC, OP_APPLY} op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} back_state_t;

  // Saturate a signed value to eff bits, returned sign-extended to 16
  function automatic logic signed [15:0] sat_amp(input logic signed [47:0] v,
                                                 input int eff);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = (48'sd1 <<< (eff - 1)) - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) return hi[15:0];
    if (v < lo) return lo[15:0];
    return v[15:0];
  endfunction

endpackage

/* rtl/core/cmva_front.sv */
// Front end: takes input beats, drops unused codes, saturates written values.
// Depends on cmva_pkg.
module cmva_front import cmva_pkg::*; #(
  parameter int AMP_WIDTH = 16
) (
  input  logic  start,
  input  item_t item,
  input  logic  full,
  output logic  push,
  output cmd_t  cmd
);

  localparam int EFF = (AMP_WIDTH < 16) ? AMP_WIDTH : 16;

  logic known;

  // Classify the function code
  always_comb begin
    known = 1'b1;
    cmd.op = OP_MAT;
    case (item.func)
      FUNC_MAT:   cmd.op = OP_MAT;
      FUNC_VEC:   cmd.op = OP_VEC;
      FUNC_APPLY: cmd.op = OP_APPLY;
      default:    known = 1'b0;
    endcase
    cmd.row = item.row;
    cmd.col = item.col;
    cmd.re  = sat_amp(48'(item.value_re), EFF);
    cmd.im  = sat_amp(48'(item.value_im), EFF);
  end

  assign push = start && !full && known;

endmodule

/* rtl/core/cmva_queue.sv */
// Two-entry command queue between front and back end.
// Depends on cmva_pkg.
module cmva_queue import cmva_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic empty,
  output logic full
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

/* rtl/core/cmva_back.sv */
// Back end: matrix memory, state vector, complex MAC pipeline and result port.
// Depends on cmva_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cmva_back import cmva_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int AMP_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  cmd_t        q_cmd,
  input  logic        q_empty,
  output logic        pop,
  output logic        result_valid,
  output result_t     result
);

  localparam int DIM   = (MAX_STATES < 16) ? MAX_STATES : 16;
  localparam int IW    = $clog2(DIM);
  localparam int NW    = IW + 1;
  localparam int AW    = $clog2(DIM * DIM);
  localparam int EFF   = (AMP_WIDTH < 16) ? AMP_WIDTH : 16;
  localparam int ACC_W = 33 + NW;

  back_state_t state, state_next;
  logic [4:0]    cnt;
  logic [NW-1:0] n_eff, last_idx;
  logic [IW-1:0] i, j;
  logic          i_last, j_last;

  logic signed [15:0] mem_re [DIM*DIM];
  logic signed [15:0] mem_im [DIM*DIM];
  logic signed [15:0] vec_re [DIM];
  logic signed [15:0] vec_im [DIM];
  logic signed [15:0] nbuf_re [DIM];
  logic signed [15:0] nbuf_im [DIM];

  logic          mat_we, vec_we, row_ok, col_ok;
  logic [AW-1:0] waddr, raddr;

  // stage 1: operands
  logic               s1_v, s1_first, s1_end;
  logic [IW-1:0]      s1_row;
  logic signed [15:0] s1_a, s1_b, s1_c, s1_d;
  // stage 2: products
  logic               s2_v, s2_first, s2_end;
  logic [IW-1:0]      s2_row;
  logic signed [31:0] p_ac, p_bd, p_ad, p_bc;
  // stage 3: accumulators
  logic               s3_v, s3_end;
  logic [IW-1:0]      s3_row;
  logic signed [ACC_W-1:0] acc_re, acc_im, term_re, term_im;
  logic signed [ACC_W:0]   rnd_re, rnd_im;
  logic               commit;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) cnt <= 5'd16;
    else if (cfg_we) cnt <= cfg_data;
  end

  // Count in use: zero acts as one, large values clip to the dimension
  always_comb begin
    if (cnt == 5'd0) n_eff = NW'(1);
    else if (int'(cnt) > DIM) n_eff = NW'(DIM);
    else n_eff = NW'(cnt);
    last_idx = n_eff - NW'(1);
  end

  assign i_last = ({1'b0, i} == last_idx);
  assign j_last = ({1'b0, j} == last_idx);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    case (state)
      ST_IDLE: begin
        pop = !q_empty;
        if (!q_empty && q_cmd.op == OP_APPLY) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (i_last && j_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Row and column walk
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else if (pop) begin
      i <= '0;
      j <= '0;
    end else if (state == ST_RUN) begin
      if (j_last) begin
        j <= '0;
        i <= i + IW'(1);
      end else begin
        j <= j + IW'(1);
      end
    end
  end

  // Write decode
  always_comb begin
    row_ok = int'(q_cmd.row) < DIM;
    col_ok = int'(q_cmd.col) < DIM;
    mat_we = pop && q_cmd.op == OP_MAT && row_ok && col_ok;
    vec_we = pop && q_cmd.op == OP_VEC && row_ok;
    waddr  = AW'(int'(q_cmd.row) * DIM + int'(q_cmd.col));
    raddr  = AW'(int'(i) * DIM + int'(j));
  end

  // Matrix memory, registered read
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mem_re[waddr] <= q_cmd.re;
      mem_im[waddr] <= q_cmd.im;
    end
    s1_a <= mem_re[raddr];
    s1_b <= mem_im[raddr];
    s1_c <= vec_re[j];
    s1_d <= vec_im[j];
  end

  // State vector: direct writes and end-of-run commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIM; k++) begin
        vec_re[k] <= '0;
        vec_im[k] <= '0;
      end
    end else if (vec_we) begin
      vec_re[q_cmd.row[IW-1:0]] <= q_cmd.re;
      vec_im[q_cmd.row[IW-1:0]] <= q_cmd.im;
    end else if (state == ST_DRAIN && commit) begin
      for (int k = 0; k < DIM; k++) begin
        if (k < int'(n_eff)) begin
          vec_re[k] <= nbuf_re[k];
          vec_im[k] <= nbuf_im[k];
        end
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_RUN);
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // Pipeline tags and products
  always_ff @(posedge clk) begin
    s1_first <= (j == '0);
    s1_end   <= j_last;
    s1_row   <= i;
    s2_first <= s1_first;
    s2_end   <= s1_end;
    s2_row   <= s1_row;
    p_ac <= s1_a * s1_c;
    p_bd <= s1_b * s1_d;
    p_ad <= s1_a * s1_d;
    p_bc <= s1_b * s1_c;
    s3_end <= s2_end;
    s3_row <= s2_row;
  end

  // Accumulate
  always_comb begin
    term_re = ACC_W'(p_ac) - ACC_W'(p_bd);
    term_im = ACC_W'(p_ad) + ACC_W'(p_bc);
    rnd_re = ((ACC_W+1)'(acc_re) + (ACC_W+1)'(ROUND_BIAS)) >>> FRAC_BITS;
    rnd_im = ((ACC_W+1)'(acc_im) + (ACC_W+1)'(ROUND_BIAS)) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      acc_re <= s2_first ? term_re : acc_re + term_re;
      acc_im <= s2_first ? term_im : acc_im + term_im;
    end
  end

  // Round, saturate, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      commit       <= 1'b0;
    end else begin
      result_valid <= s3_v && s3_end;
      commit       <= s3_v && s3_end && ({1'b0, s3_row} == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v && s3_end) begin
      result.index  <= 4'(s3_row);
      result.amp_re <= sat_amp(48'(rnd_re), EFF);
      result.amp_im <= sat_amp(48'(rnd_im), EFF);
      result.last   <= ({1'b0, s3_row} == last_idx);
      nbuf_re[s3_row] <= sat_amp(48'(rnd_re), EFF);
      nbuf_im[s3_row] <= sat_amp(48'(rnd_im), EFF);
    end
  end

  `CHECK_IMPL(a_res_in_run, clk, rst, result_valid |-> state != ST_IDLE, "result while idle")
  `CHECK_IMPL(a_last_commit, clk, rst, (result_valid && result.last) |-> commit, "last w/o commit")
  `CHECK_IMPL(a_commit_idle, clk, rst, commit |=> state == ST_IDLE, "commit did not end run")
  `CHECK_NEVER(a_pop_busy, clk, rst, pop && state != ST_IDLE, "pop during run")

endmodule

/* rtl/core/complex_matrix_vector_apply_top.sv */
// Top level of the complex matrix-vector block.
// Depends on cmva_pkg, cmva_front, cmva_queue, cmva_back.
//
// Usage:
//   Input: an item beat is taken at a rising edge with start high and busy
//   low. func 0 writes a matrix entry, 1 a state entry, 2 applies the matrix.
//   Code 3 is taken and dropped.
//   Config: cfg_we writes cfg_data into state_count (n); write only when idle.
//   Output: result_valid marks one result beat per cycle; it cannot be held.
//   An apply emits n beats in index order, last set on the final one.
// Timing:
//   Writes retire one per cycle while the back end is idle; busy rises only
//   when the two-entry command queue is full. An apply walks n*n complex MACs
//   through the matrix memory read port, one per cycle; the beat for row r
//   passes the operand, product, accumulator and output registers.
// Reset:
//   rst clears the state vector to zero, sets state_count to 16 and empties
//   the queue. Matrix entries hold garbage until written.
module complex_matrix_vector_apply_top import cmva_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int AMP_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  output logic       result_valid,
  output result_t    result
);

  logic push, pop, q_empty, q_full;
  cmd_t f_cmd, q_cmd;

  assign busy = q_full;

  cmva_front #(.AMP_WIDTH(AMP_WIDTH)) u_front (
    .start (start),
    .item  (item),
    .full  (q_full),
    .push  (push),
    .cmd   (f_cmd)
  );

  cmva_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_cmd),
    .pop   (pop),
    .dout  (q_cmd),
    .empty (q_empty),
    .full  (q_full)
  );

  cmva_back #(.MAX_STATES(MAX_STATES), .AMP_WIDTH(AMP_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .q_cmd        (q_cmd),
    .q_empty      (q_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

/* tb/complex_matrix_vector_apply_checker.sv */
`timescale 1ns / 100ps
// Checker for the complex matrix-vector block: predicts apply results and
// compares them to the result beats. Depends on cmva_pkg.
module complex_matrix_vector_apply_checker import cmva_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  item_t      item,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       result_valid,
  input  result_t    result,
  output int         fail_count,
  output int         pending
);

  localparam int DIM = 16;

  logic signed [15:0] mat_re [DIM*DIM];
  logic signed [15:0] mat_im [DIM*DIM];
  logic signed [15:0] vec_re [DIM];
  logic signed [15:0] vec_im [DIM];
  logic [4:0]         count_reg;
  result_t            amp_queue [$];

  // Q2.28 sum to Q1.14, round half up, saturate to 16 bits
  function automatic logic signed [15:0] round_sat(input longint acc);
    longint t;
    longint r;
    t = acc + ROUND_BIAS;
    r = t >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Multiply the stored vector by the matrix and queue the new entries
  task automatic predict_apply();
    int n;
    longint acc_re;
    longint acc_im;
    logic signed [15:0] nre [DIM];
    logic signed [15:0] nim [DIM];
    result_t r;
    n = (count_reg == 0) ? 1 : (count_reg > DIM ? DIM : int'(count_reg));
    for (int i = 0; i < n; i++) begin
      acc_re = 0;
      acc_im = 0;
      for (int j = 0; j < n; j++) begin
        acc_re += longint'(mat_re[i*DIM+j]) * vec_re[j] - longint'(mat_im[i*DIM+j]) * vec_im[j];
        acc_im += longint'(mat_re[i*DIM+j]) * vec_im[j] + longint'(mat_im[i*DIM+j]) * vec_re[j];
      end
      nre[i] = round_sat(acc_re);
      nim[i] = round_sat(acc_im);
    end
    for (int i = 0; i < n; i++) begin
      vec_re[i] = nre[i];
      vec_im[i] = nim[i];
      r.index = i[3:0];
      r.amp_re = nre[i];
      r.amp_im = nim[i];
      r.last = (i == n - 1);
      amp_queue.push_back(r);
    end
  endtask

  // Track beats and compare results
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (vec_re[k]) begin
        vec_re[k] = '0;
        vec_im[k] = '0;
      end
      count_reg = 5'd16;
      amp_queue.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        if (amp_queue.size() == 0) begin
          $error("unexpected result beat index %0d", result.index);
          fail_count++;
        end else begin
          want = amp_queue.pop_front();
          if (result.index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, result.index);
            fail_count++;
          end
          if (result.amp_re !== want.amp_re) begin
            $error("amp_re: expected %0d, got %0d", want.amp_re, result.amp_re);
            fail_count++;
          end
          if (result.amp_im !== want.amp_im) begin
            $error("amp_im: expected %0d, got %0d", want.amp_im, result.amp_im);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, result.last);
            fail_count++;
          end
        end
      end
      if (cfg_we) count_reg = cfg_data;
      if (start && !busy) begin
        case (item.func)
          FUNC_MAT: begin
            mat_re[item.row*DIM+item.col] = item.value_re;
            mat_im[item.row*DIM+item.col] = item.value_im;
          end
          FUNC_VEC: begin
            vec_re[item.row] = item.value_re;
            vec_im[item.row] = item.value_im;
          end
          FUNC_APPLY: predict_apply();
          default: ;
        endcase
      end
    end
    pending = amp_queue.size();
  end

endmodule

/* tb/complex_matrix_vector_apply_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for complex_matrix_vector_apply_top: drives item and config
// beats and gives the verdict. Depends on cmva_pkg and the checker module.
module complex_matrix_vector_apply_top_test;
  import cmva_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  item_t      item;
  logic       cfg_we;
  logic [4:0] cfg_data;
  logic       result_valid;
  result_t    result;
  int         fail_count;
  int         pending;
  int         cycle_count = 0;
  int         sent = 0;

  complex_matrix_vector_apply_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid),
    .result(result)
  );

  complex_matrix_vector_apply_checker amp_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid),
    .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("complex_matrix_vector_apply_top verification failed");
      $finish;
    end
  end

  // Random sample with the extremes favored
  function automatic logic [15:0] rand_amp();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one item beat, mostly back to back, sometimes with a gap
  task automatic send_item(input logic [1:0] f, input logic [3:0] r,
                           input logic [3:0] c, input logic [15:0] re,
                           input logic [15:0] im, input bit gaps);
    int gap;
    gap = 0;
    if (gaps && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= '{func: f, row: r, col: c, value_re: re, value_im: im};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write the whole matrix within the count in use
  task automatic load_matrix(input int n, input bit gaps);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        send_item(FUNC_MAT, i[3:0], j[3:0], rand_amp(), rand_amp(), gaps);
  endtask

  task automatic set_count(input logic [4:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: apply on the cleared vector at reset count needs a full matrix
    load_matrix(16, 1'b0);
    send_item(FUNC_APPLY, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0);
    // Count two with extreme matrix and vector entries
    set_count(5'd2);
    send_item(FUNC_MAT, 4'd0, 4'd0, 16'h7fff, 16'h8000, 1'b0);
    send_item(FUNC_MAT, 4'd0, 4'd1, 16'h8000, 16'h8000, 1'b0);
    send_item(FUNC_MAT, 4'd1, 4'd0, 16'h4000, 16'h0000, 1'b0);
    send_item(FUNC_MAT, 4'd1, 4'd1, 16'h7fff, 16'h7fff, 1'b0);
    send_item(FUNC_VEC, 4'd0, 4'd9, 16'h8000, 16'h7fff, 1'b0);
    send_item(FUNC_VEC, 4'd1, 4'd0, 16'h7fff, 16'h8000, 1'b0);
    send_item(FUNC_VEC, 4'd15, 4'd15, 16'hffff, 16'h0001, 1'b0);
    send_item(FUNC_MAT, 4'd15, 4'd15, 16'h1234, 16'hedcb, 1'b0);
    send_item(FUNC_UNUSED, 4'd15, 4'd15, 16'hffff, 16'hffff, 1'b0);
    send_item(FUNC_APPLY, 4'd15, 4'd15, 16'hffff, 16'hffff, 1'b0);
    send_item(FUNC_APPLY, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0);
    // Count zero acts as one
    set_count(5'd0);
    send_item(FUNC_VEC, 4'd0, 4'd0, 16'h2000, 16'hc000, 1'b0);
    send_item(FUNC_APPLY, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0);
    // Counts above the limit saturate
    set_count(5'd31);
    send_item(FUNC_APPLY, 4'd0, 4'd0, 16'h0, 16'h0, 1'b0);

    // Random phases: mostly small sizes, now and then a larger one
    while (sent < 300) begin
      case ($urandom_range(0, 9))
        0: n = 8;
        1: n = 1;
        default: n = $urandom_range(1, 5);
      endcase
      set_count(n[4:0]);
      load_matrix(n, 1'b1);
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_item(FUNC_APPLY, 4'($urandom), 4'($urandom),
                                16'($urandom), 16'($urandom), 1'b1);
          4: send_item(FUNC_UNUSED, 4'($urandom), 4'($urandom), rand_amp(), rand_amp(),
                       1'b1);
          5: send_item(FUNC_MAT, 4'($urandom), 4'($urandom), rand_amp(), rand_amp(), 1'b1);
          default: send_item(FUNC_VEC, 4'($urandom), 4'($urandom),
                             rand_amp(), rand_amp(), 1'b1);
        endcase
        // Now and then pause until every result is back
        if ($urandom_range(0, 15) == 0) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("complex_matrix_vector_apply_top verification clean");
    end else begin
      $display("complex_matrix_vector_apply_top verification failed");
    end
    $finish;
  end

endmodule
